// File: design/acfm_pkg.sv
// Shared types, command codes and the rule match function of the ACL classifier.
package acfm_pkg;

  localparam int MAX_RULES = 64;
  localparam int NUM_ACLS  = 4;
  localparam int ADDR_W    = $clog2(MAX_RULES);
  localparam int CNT_W     = ADDR_W + 1;

  // Command codes
  localparam logic [2:0] CMD_CLASSIFY  = 3'd0;
  localparam logic [2:0] CMD_ADD_RULE  = 3'd1;
  localparam logic [2:0] CMD_REMOVE    = 3'd2;
  localparam logic [2:0] CMD_CLEAR     = 3'd3;
  localparam logic [2:0] CMD_CREATE    = 3'd4;
  localparam logic [2:0] CMD_DELETE    = 3'd5;
  localparam logic [2:0] CMD_CLEAR_ALL = 3'd6;

  // Actions and verdicts
  localparam logic [1:0] ACT_PERMIT   = 2'd0;
  localparam logic [1:0] ACT_DENY     = 2'd1;
  localparam logic [1:0] ACT_REDIRECT = 2'd2;

  localparam logic [15:0] ETH_IPV4  = 16'h0800;
  localparam logic [7:0]  PROTO_TCP = 8'd6;
  localparam logic [7:0]  PROTO_UDP = 8'd17;

  // One stored rule
  typedef struct packed {
    logic [31:0] rule_id;
    logic [15:0] prio;
    logic [1:0]  acl;
    logic [9:0]  flags;
    logic [1:0]  action;
    logic [15:0] rport;
    logic [47:0] src_mac;
    logic [47:0] dst_mac;
    logic [27:0] l2;
    logic [63:0] ips;
    logic [39:0] l4;
  } entry_t;

  // One decoded command travelling through the queue
  typedef struct packed {
    logic [2:0]  op;
    entry_t      rule;
    logic        eth;
    logic        vlan;
    logic        ip_ok;
    logic        l4_ok;
    logic [15:0] etype;
  } cmd_t;

  // Does stored rule e match the packet carried in c?
  function automatic logic rule_match(input entry_t e, input cmd_t c);
    logic [8:0] cares;
    logic       m;
    begin
      cares = e.flags[8:0];
      m = 1'b1;
      if (cares[0] && (!c.eth || c.rule.src_mac != e.src_mac)) m = 1'b0;
      if (cares[1] && (!c.eth || c.rule.dst_mac != e.dst_mac)) m = 1'b0;
      if (cares[2] && (!c.eth || !c.vlan || c.rule.l2[27:16] != e.l2[27:16])) m = 1'b0;
      if (!c.eth && (cares[8:3] != 6'd0)) m = 1'b0;
      if (cares[3] && c.etype != e.l2[15:0]) m = 1'b0;
      if (cares[8:4] != 5'd0) begin
        if (!c.ip_ok) m = 1'b0;
        if (cares[4] && c.rule.ips[63:32] != e.ips[63:32]) m = 1'b0;
        if (cares[5] && c.rule.ips[31:0] != e.ips[31:0]) m = 1'b0;
        if (cares[6] && c.rule.l4[39:32] != e.l4[39:32]) m = 1'b0;
        if (cares[8:7] != 2'd0) begin
          if (!c.l4_ok) m = 1'b0;
          if (cares[7] && c.rule.l4[31:16] != e.l4[31:16]) m = 1'b0;
          if (cares[8] && c.rule.l4[15:0] != e.l4[15:0]) m = 1'b0;
        end
      end
      return m;
    end
  endfunction

endpackage

// File: design/acfm_front.sv
// Front end: accepts commands, decodes packet header predicates, feeds the queue.
module acfm_front (
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [2:0]          cmd,
  input  logic [1:0]          acl_id,
  input  logic [31:0]         rule_id,
  input  logic [15:0]         priority_req,
  input  logic [1:0]          action,
  input  logic [15:0]         redirect_port,
  input  logic [13:0]         field_flags,
  input  logic [47:0]         src_mac,
  input  logic [47:0]         dst_mac,
  input  logic [27:0]         vlan_ethertype,
  input  logic [63:0]         ip_addrs,
  input  logic [39:0]         proto_ports,
  input  logic                q_full,
  output logic                q_push,
  output acfm_pkg::cmd_t      q_data
);
  import acfm_pkg::*;

  logic eth;
  logic [15:0] etype;
  logic [7:0]  proto;

  // Packet header presence and effective ethertype
  assign eth   = field_flags[10];
  assign etype = eth ? vlan_ethertype[15:0] : 16'd0;
  assign proto = proto_ports[39:32];

  // Queue write side
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_data.op           = cmd;
    q_data.rule.rule_id = rule_id;
    q_data.rule.prio    = priority_req;
    q_data.rule.acl     = acl_id;
    q_data.rule.flags   = field_flags[9:0];
    q_data.rule.action  = action;
    q_data.rule.rport   = redirect_port;
    q_data.rule.src_mac = src_mac;
    q_data.rule.dst_mac = dst_mac;
    q_data.rule.l2      = vlan_ethertype;
    q_data.rule.ips     = ip_addrs;
    q_data.rule.l4      = proto_ports;
    q_data.eth          = eth;
    q_data.vlan         = field_flags[11];
    q_data.ip_ok        = eth && (etype == ETH_IPV4) && field_flags[12];
    q_data.l4_ok        = ((proto == PROTO_TCP) || (proto == PROTO_UDP)) && field_flags[13];
    q_data.etype        = etype;
  end

endmodule

// File: design/acfm_fifo.sv
// Two-entry command queue between the front end and the table engine.
module acfm_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  acfm_pkg::cmd_t  wr_data,
  output logic            full,
  input  logic            pop,
  output logic            q_valid,
  output acfm_pkg::cmd_t  rd_data
);
  import acfm_pkg::*;

  cmd_t       store [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign rd_data = store[rptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      store[wptr] <= wr_data;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop)  rptr <= ~rptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: design/acfm_engine.sv
// Back end: rule memory, ACL table and the one-entry-per-cycle scan of rule commands.
module acfm_engine (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  acfm_pkg::cmd_t  q_data,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [1:0]      verdict,
  output logic [15:0]     redirect_port_out,
  output logic            matched,
  output logic [31:0]     matched_rule,
  output logic            ok
);
  import acfm_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  entry_t mem [MAX_RULES];
  entry_t rd;

  logic                 state;
  cmd_t                 cur;
  logic [CNT_W-1:0]     addr;
  logic                 pv;
  logic [ADDR_W-1:0]    pidx;
  logic [MAX_RULES-1:0] valid;
  logic [NUM_ACLS-1:0]  acl_exists;

  logic              best_found;
  logic [15:0]       best_prio;
  logic [31:0]       best_id;
  logic [1:0]        best_act;
  logic              best_pg;
  logic [15:0]       best_port;
  logic              same_found;
  logic [ADDR_W-1:0] same_slot;
  logic              free_found;
  logic [ADDR_W-1:0] free_slot;
  logic              removed;

  logic              live;
  logic              scan_end;
  logic              hit;
  logic              id_eq;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_slot;

  assign live     = acl_exists[q_data.rule.acl];
  assign scan_end = (state == S_SCAN) && (addr == CNT_W'(MAX_RULES)) && !pv;
  assign hit      = pv && valid[pidx] && (rd.acl == cur.rule.acl);
  assign id_eq    = (rd.rule_id == cur.rule.rule_id);
  assign pop      = (state == S_IDLE) && q_valid && !out_valid;
  assign wr_en    = scan_end && (cur.op == CMD_ADD_RULE) && (same_found || free_found);
  assign wr_slot  = same_found ? same_slot : free_slot;

  // Rule memory: one read per cycle, written by add at the end of its scan
  always_ff @(posedge clk) begin
    if (state == S_SCAN && addr != CNT_W'(MAX_RULES)) begin
      rd <= mem[addr[ADDR_W-1:0]];
    end
    if (wr_en) begin
      mem[wr_slot] <= cur.rule;
    end
  end

  // Control, table state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      addr       <= '0;
      pv         <= 1'b0;
      valid      <= '0;
      acl_exists <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (pop) begin
            cur               <= q_data;
            addr              <= '0;
            pv                <= 1'b0;
            best_found        <= 1'b0;
            same_found        <= 1'b0;
            free_found        <= 1'b0;
            removed           <= 1'b0;
            verdict           <= ACT_PERMIT;
            redirect_port_out <= 16'd0;
            matched           <= 1'b0;
            matched_rule      <= 32'd0;
            ok                <= 1'b0;
            case (q_data.op)
              CMD_CLASSIFY, CMD_ADD_RULE, CMD_REMOVE, CMD_CLEAR, CMD_DELETE: begin
                if (live) state <= S_SCAN;
                else out_valid <= 1'b1;
              end
              CMD_CREATE: begin
                if (!live) begin
                  acl_exists[q_data.rule.acl] <= 1'b1;
                  ok <= 1'b1;
                end
                out_valid <= 1'b1;
              end
              CMD_CLEAR_ALL: begin
                acl_exists <= '0;
                valid      <= '0;
                ok         <= 1'b1;
                out_valid  <= 1'b1;
              end
              default: begin
                out_valid <= 1'b1;
              end
            endcase
          end
        end

        S_SCAN: begin
          // Issue the next read
          if (addr != CNT_W'(MAX_RULES)) begin
            pv   <= 1'b1;
            pidx <= addr[ADDR_W-1:0];
            addr <= addr + CNT_W'(1);
          end else begin
            pv <= 1'b0;
          end

          // Evaluate the entry read last cycle
          case (cur.op)
            CMD_CLASSIFY: begin
              if (hit && rule_match(rd, cur) &&
                  (!best_found || rd.prio > best_prio ||
                   (rd.prio == best_prio && rd.rule_id < best_id))) begin
                best_found <= 1'b1;
                best_prio  <= rd.prio;
                best_id    <= rd.rule_id;
                best_act   <= rd.action;
                best_pg    <= rd.flags[9];
                best_port  <= rd.rport;
              end
            end
            CMD_ADD_RULE: begin
              if (hit && id_eq && !same_found) begin
                same_found <= 1'b1;
                same_slot  <= pidx;
              end
              if (pv && !valid[pidx] && !free_found) begin
                free_found <= 1'b1;
                free_slot  <= pidx;
              end
            end
            CMD_REMOVE: begin
              if (hit && id_eq) begin
                valid[pidx] <= 1'b0;
                removed     <= 1'b1;
              end
            end
            CMD_CLEAR, CMD_DELETE: begin
              if (hit) valid[pidx] <= 1'b0;
            end
            default: begin
            end
          endcase

          // Scan finished: settle the result
          if (scan_end) begin
            state     <= S_IDLE;
            out_valid <= 1'b1;
            case (cur.op)
              CMD_CLASSIFY: begin
                ok <= 1'b1;
                if (best_found) begin
                  matched      <= 1'b1;
                  matched_rule <= best_id;
                  if (best_act == ACT_REDIRECT && !best_pg) begin
                    verdict <= ACT_DENY;
                  end else begin
                    verdict <= best_act;
                  end
                  if (best_act == ACT_REDIRECT && best_pg) redirect_port_out <= best_port;
                end
              end
              CMD_ADD_RULE: begin
                if (same_found || free_found) begin
                  valid[wr_slot] <= 1'b1;
                  ok <= 1'b1;
                end
              end
              CMD_REMOVE: ok <= removed;
              CMD_CLEAR:  ok <= 1'b1;
              CMD_DELETE: begin
                acl_exists[cur.rule.acl] <= 1'b0;
                ok <= 1'b1;
              end
              default: ok <= 1'b0;
            endcase
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: design/acl_first_match_classifier.sv
// Top level of the first-match ACL classifier: front end, command queue and table engine.
// Each command yields one result transfer. Classify, add, remove, clear and delete of a
// live ACL walk the whole rule memory, one entry per cycle through its single read port,
// before their result is valid; create, clear-all, unknown commands and commands on a
// missing ACL settle their result from the idle state without a scan. A new command leaves
// the queue once the previous result has been transferred, while the front end keeps
// accepting up to two commands into the queue. There is no clearing pass: reset empties
// the table at once.
module acl_first_match_classifier (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  cmd,
  input  logic [1:0]  acl_id,
  input  logic [31:0] rule_id,
  input  logic [15:0] priority_req,
  input  logic [1:0]  action,
  input  logic [15:0] redirect_port,
  input  logic [13:0] field_flags,
  input  logic [47:0] src_mac,
  input  logic [47:0] dst_mac,
  input  logic [27:0] vlan_ethertype,
  input  logic [63:0] ip_addrs,
  input  logic [39:0] proto_ports,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  verdict,
  output logic [15:0] redirect_port_out,
  output logic        matched,
  output logic [31:0] matched_rule,
  output logic        ok
);
  import acfm_pkg::*;

  logic q_full;
  logic q_push;
  logic q_valid;
  logic q_pop;
  cmd_t q_wr;
  cmd_t q_rd;

  acfm_front u_front (
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .cmd            (cmd),
    .acl_id         (acl_id),
    .rule_id        (rule_id),
    .priority_req   (priority_req),
    .action         (action),
    .redirect_port  (redirect_port),
    .field_flags    (field_flags),
    .src_mac        (src_mac),
    .dst_mac        (dst_mac),
    .vlan_ethertype (vlan_ethertype),
    .ip_addrs       (ip_addrs),
    .proto_ports    (proto_ports),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_data         (q_wr)
  );

  acfm_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (q_wr),
    .full    (q_full),
    .pop     (q_pop),
    .q_valid (q_valid),
    .rd_data (q_rd)
  );

  acfm_engine u_engine (
    .clk               (clk),
    .rst               (rst),
    .q_valid           (q_valid),
    .q_data            (q_rd),
    .pop               (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .verdict           (verdict),
    .redirect_port_out (redirect_port_out),
    .matched           (matched),
    .matched_rule      (matched_rule),
    .ok                (ok)
  );

`ifndef NO_ASSERTIONS
  // The engine never takes from an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid) else $error("queue popped while empty");

  // A matched rule implies the addressed ACL was live
  a_match_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && matched) |-> ok) else $error("match reported without live ACL");

  // Any non-permit verdict comes from a matched rule
  a_verdict_match: assert property (@(posedge clk) disable iff (rst)
    (out_valid && verdict != ACT_PERMIT) |-> matched) else $error("verdict without match");

  // A redirect port is only reported with a redirect verdict
  a_port_redirect: assert property (@(posedge clk) disable iff (rst)
    (out_valid && redirect_port_out != 16'd0) |-> (verdict == ACT_REDIRECT))
    else $error("redirect port without redirect verdict");
`endif

endmodule

// File: dv/tb.sv
// Self-checking testbench for the first-match ACL classifier.
`timescale 1ns / 100ps

module tb;
  import acfm_pkg::*;

  localparam int WDOG_LIMIT = 4000;
  localparam logic [2:0] CMD_UNKNOWN = 3'd7;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  cmd;
  logic [1:0]  acl_id;
  logic [31:0] rule_id;
  logic [15:0] priority_req;
  logic [1:0]  action;
  logic [15:0] redirect_port;
  logic [13:0] field_flags;
  logic [47:0] src_mac;
  logic [47:0] dst_mac;
  logic [27:0] vlan_ethertype;
  logic [63:0] ip_addrs;
  logic [39:0] proto_ports;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  verdict;
  logic [15:0] redirect_port_out;
  logic        matched;
  logic [31:0] matched_rule;
  logic        ok;

  acl_first_match_classifier uut (.*);

  // One command as driven on the input side
  typedef struct {
    logic [2:0]  op;
    logic [1:0]  acl;
    logic [31:0] rid;
    logic [15:0] prio;
    logic [1:0]  act;
    logic [15:0] rport;
    logic [13:0] flags;
    logic [47:0] smac;
    logic [47:0] dmac;
    logic [27:0] l2;
    logic [63:0] ips;
    logic [39:0] l4;
  } command_t;

  typedef struct {
    logic [1:0]  verdict;
    logic [15:0] rport;
    logic        matched;
    logic [31:0] rule;
    logic        ok;
  } verdict_t;

  // Shadow of the rule table
  bit          acl_live_q [NUM_ACLS];
  bit          slot_used [MAX_RULES];
  command_t    slot_rule [MAX_RULES];
  verdict_t    pending_verdicts[$];
  command_t    stim_table[$];
  logic        stim_known[$];
  verdict_t    stim_expect[$];

  int errors = 0;
  int n_sent = 0, n_checked = 0, n_classify = 0, n_hits = 0;
  int idle_cycles = 0;
  bit no_idle = 0;
  bit finished = 0;
  // Rule ids of accepted adds, for well-formed removes
  logic [31:0] id_pool[$];

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  function automatic bit rule_hits(command_t r, command_t p);
    logic [8:0]  cares;
    bit          eth, vlan, ip4, l4h;
    logic [15:0] etype;
    logic [7:0]  proto;
    cares = r.flags[8:0];
    eth   = p.flags[10];
    vlan  = p.flags[11];
    ip4   = p.flags[12];
    l4h   = p.flags[13];
    etype = eth ? p.l2[15:0] : 16'h0;
    proto = p.l4[39:32];
    if (cares[0] && (!eth || p.smac != r.smac)) return 0;
    if (cares[1] && (!eth || p.dmac != r.dmac)) return 0;
    if (cares[2] && (!eth || !vlan || p.l2[27:16] != r.l2[27:16])) return 0;
    if (!eth && cares[8:3] != 0) return 0;
    if (cares[3] && etype != r.l2[15:0]) return 0;
    if (cares[8:4] != 0) begin
      if (etype != ETH_IPV4 || !ip4) return 0;
      if (cares[4] && p.ips[63:32] != r.ips[63:32]) return 0;
      if (cares[5] && p.ips[31:0] != r.ips[31:0]) return 0;
      if (cares[6] && proto != r.l4[39:32]) return 0;
      if (cares[8:7] != 0) begin
        if ((proto != PROTO_TCP && proto != PROTO_UDP) || !l4h) return 0;
        if (cares[7] && p.l4[31:16] != r.l4[31:16]) return 0;
        if (cares[8] && p.l4[15:0] != r.l4[15:0]) return 0;
      end
    end
    return 1;
  endfunction

  // Apply one command to the shadow table and return its verdict
  function automatic verdict_t apply_command(command_t c);
    verdict_t v;
    int best, slot;
    v = '{default: 0};
    best = -1;
    slot = -1;
    case (c.op)
      CMD_CLASSIFY: begin
        v.ok = acl_live_q[c.acl];
        if (v.ok)
          for (int i = 0; i < MAX_RULES; i++)
            if (slot_used[i] && slot_rule[i].acl == c.acl && rule_hits(slot_rule[i], c))
              if (best < 0 || slot_rule[i].prio > slot_rule[best].prio ||
                  (slot_rule[i].prio == slot_rule[best].prio &&
                   slot_rule[i].rid < slot_rule[best].rid))
                best = i;
        if (best >= 0) begin
          v.matched = 1;
          v.rule = slot_rule[best].rid;
          v.verdict = slot_rule[best].act;
          if (v.verdict == ACT_REDIRECT) begin
            if (slot_rule[best].flags[9]) v.rport = slot_rule[best].rport;
            else v.verdict = ACT_DENY;
          end
        end
      end
      CMD_ADD_RULE: if (acl_live_q[c.acl]) begin
        for (int i = 0; i < MAX_RULES; i++)
          if (slot < 0 && slot_used[i] && slot_rule[i].acl == c.acl && slot_rule[i].rid == c.rid)
            slot = i;
        for (int i = 0; i < MAX_RULES; i++)
          if (slot < 0 && !slot_used[i]) slot = i;
        if (slot >= 0) begin
          slot_used[slot] = 1;
          slot_rule[slot] = c;
          slot_rule[slot].flags = {4'b0, c.flags[9:0]};
          v.ok = 1;
        end
      end
      CMD_REMOVE: if (acl_live_q[c.acl])
        for (int i = 0; i < MAX_RULES; i++)
          if (slot_used[i] && slot_rule[i].acl == c.acl && slot_rule[i].rid == c.rid) begin
            slot_used[i] = 0;
            v.ok = 1;
          end
      CMD_CLEAR, CMD_DELETE: if (acl_live_q[c.acl]) begin
        for (int i = 0; i < MAX_RULES; i++)
          if (slot_rule[i].acl == c.acl) slot_used[i] = 0;
        if (c.op == CMD_DELETE) acl_live_q[c.acl] = 0;
        v.ok = 1;
      end
      CMD_CREATE: if (!acl_live_q[c.acl]) begin
        acl_live_q[c.acl] = 1;
        v.ok = 1;
      end
      CMD_CLEAR_ALL: begin
        acl_live_q = '{default: 0};
        slot_used = '{default: 0};
        v.ok = 1;
      end
      default: ;
    endcase
    return v;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("%0t mismatch on %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  // Random command; packets often reuse a stored rule's fields so rules hit
  function automatic command_t random_command();
    command_t c;
    int r, k;
    c.op    = 3'($urandom_range(0, 7));
    c.acl   = 2'($urandom);
    c.rid   = ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(0, 15));
    c.prio  = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
    c.act   = 2'($urandom);
    c.rport = 16'($urandom);
    c.flags = 14'($urandom);
    c.smac  = {16'($urandom), $urandom};
    c.dmac  = {16'($urandom), $urandom};
    c.l2    = 28'($urandom);
    c.ips   = {$urandom, $urandom};
    c.l4    = {8'($urandom), $urandom};
    r = $urandom_range(0, 99);
    if (r < 45) c.op = CMD_CLASSIFY;
    else if (r < 75) c.op = CMD_ADD_RULE;
    else if (r < 83) c.op = CMD_REMOVE;
    else if (r < 90) c.op = CMD_CREATE;
    // rules care for few fields, so that matches are common
    if (c.op == CMD_ADD_RULE) c.flags[8:0] = c.flags[8:0] & 9'($urandom);
    if (c.op == CMD_ADD_RULE && $urandom_range(0, 1)) c.flags[8:0] = 9'($urandom) & 9'h00f;
    if (c.op == CMD_REMOVE && id_pool.size() > 0)
      c.rid = id_pool[$urandom_range(0, id_pool.size() - 1)];
    if (c.op == CMD_CLASSIFY && $urandom_range(0, 3) != 0) begin
      k = $urandom_range(0, MAX_RULES - 1);
      if (slot_used[k]) begin
        c.acl = slot_rule[k].acl;
        c.smac = slot_rule[k].smac;
        c.dmac = slot_rule[k].dmac;
        c.ips = slot_rule[k].ips;
        c.l4 = slot_rule[k].l4;
        c.l2 = slot_rule[k].l2;
      end
      if ($urandom_range(0, 1)) begin
        c.l2[15:0] = ETH_IPV4;
        c.flags[13:10] = 4'hf;
        if ($urandom_range(0, 1)) c.l4[39:32] = $urandom_range(0, 1) ? PROTO_TCP : PROTO_UDP;
      end
    end
    return c;
  endfunction

  // Drive one command and wait for its transfer
  task automatic send_command(command_t c);
    verdict_t v;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    cmd <= c.op;  acl_id <= c.acl;  rule_id <= c.rid;  priority_req <= c.prio;
    action <= c.act;  redirect_port <= c.rport;  field_flags <= c.flags;
    src_mac <= c.smac;  dst_mac <= c.dmac;  vlan_ethertype <= c.l2;
    ip_addrs <= c.ips;  proto_ports <= c.l4;
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
    v = apply_command(c);
    pending_verdicts = {pending_verdicts, v};
    if (c.op == CMD_CLASSIFY) n_classify++;
    if (c.op == CMD_ADD_RULE && v.ok && id_pool.size() < 32) id_pool = {id_pool, c.rid};
    n_sent++;
    @(negedge clk);
  endtask

  // Receiver stalls in random bursts
  initial begin
    out_stall = 0;
    forever begin
      @(negedge clk);
      if (!no_idle && $urandom_range(0, 4) == 0) begin
        out_stall <= 1;
        repeat ($urandom_range(1, 3)) @(negedge clk);
      end
      out_stall <= 0;
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    verdict_t w;
    if (!rst && out_valid && !out_stall) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch("result with no command outstanding", 64'd1, 64'd0);
      end else begin
        w = pending_verdicts.pop_front();
        if (verdict !== w.verdict) report_mismatch("verdict", verdict, w.verdict);
        if (redirect_port_out !== w.rport) report_mismatch("redirect port", redirect_port_out, w.rport);
        if (matched !== w.matched) report_mismatch("matched", matched, w.matched);
        if (matched_rule !== w.rule) report_mismatch("matched rule", matched_rule, w.rule);
        if (ok !== w.ok) report_mismatch("ok", ok, w.ok);
        if (w.matched) n_hits++;
        n_checked++;
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (!finished && idle_cycles >= WDOG_LIMIT && (pending_verdicts.size() > 0 || in_valid)) begin
      $display("watchdog expired after %0d cycles without a transfer", WDOG_LIMIT);
      $display("acl_first_match_classifier regression: fail");
      $finish;
    end
  end

  // Directed row; known results only where obvious
  task automatic add_row(logic [2:0] op, logic [1:0] acl, logic [31:0] rid, logic [15:0] prio,
                         logic [1:0] act, logic [13:0] flags, bit known, logic ok_val);
    command_t c;
    verdict_t v;
    c = '{op: op, acl: acl, rid: rid, prio: prio, act: act, rport: 16'hffff, flags: flags,
          smac: 48'hffff_ffff_ffff, dmac: 48'h0, l2: {12'hfff, ETH_IPV4}, ips: '1,
          l4: {PROTO_TCP, 32'hffff_0000}};
    v = '{default: 0};
    v.ok = ok_val;
    stim_table = {stim_table, c};
    stim_known = {stim_known, known};
    stim_expect = {stim_expect, v};
  endtask

  initial begin
    command_t c;
    verdict_t want;
    verdict_t typed;
    rst = 1;
    in_valid = 0;
    {cmd, acl_id, rule_id, priority_req, action, redirect_port, field_flags} = '0;
    {src_mac, dst_mac, vlan_ethertype, ip_addrs, proto_ports} = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed table: op, acl, id, prio, action, flags, known, ok
    add_row(CMD_CLASSIFY,  0, 0, 0, 0, 14'h3c00, 1, 0);           // missing ACL permits
    add_row(CMD_REMOVE,    1, 5, 0, 0, 0, 1, 0);                  // remove on missing ACL
    add_row(CMD_ADD_RULE,  1, 5, 0, 0, 0, 1, 0);                  // add to missing ACL
    add_row(CMD_CREATE,    3, 0, 0, 0, 0, 1, 1);
    add_row(CMD_CREATE,    3, 0, 0, 0, 0, 1, 0);                  // create existing
    add_row(CMD_ADD_RULE,  3, 32'hffff_ffff, 16'hffff, ACT_REDIRECT, 14'h3ff, 0, 0);
    add_row(CMD_ADD_RULE,  3, 0, 16'hffff, ACT_REDIRECT, 14'h000, 0, 0); // redirect, no port
    add_row(CMD_CLASSIFY,  3, 0, 0, 0, 14'h3c00, 0, 0);           // equal prio, lowest id
    add_row(CMD_ADD_RULE,  3, 0, 0, 2'd3, 14'h1ff, 0, 0);         // replace in place
    add_row(CMD_CLASSIFY,  3, 0, 0, 0, 14'h3c00, 0, 0);
    add_row(CMD_CLASSIFY,  3, 0, 0, 0, 14'h0000, 0, 0);           // no eth header
    add_row(CMD_CLASSIFY,  3, 0, 0, 0, 14'h0400, 0, 0);           // eth only
    add_row(CMD_REMOVE,    3, 32'hffff_ffff, 0, 0, 0, 1, 1);
    add_row(CMD_REMOVE,    3, 32'hffff_ffff, 0, 0, 0, 1, 0);      // absent id
    add_row(CMD_CLASSIFY,  3, 0, 0, 0, 14'h3c00, 0, 0);
    add_row(CMD_CLEAR,     3, 0, 0, 0, 0, 1, 1);
    add_row(CMD_CLEAR,     2, 0, 0, 0, 0, 1, 0);                  // clear missing
    add_row(CMD_DELETE,    3, 0, 0, 0, 0, 1, 1);
    add_row(CMD_DELETE,    3, 0, 0, 0, 0, 1, 0);
    add_row(CMD_UNKNOWN,   0, 0, 0, 0, 14'h3fff, 1, 0);
    add_row(CMD_CLEAR_ALL, 0, 0, 0, 0, 0, 1, 1);
    for (int a = 0; a < NUM_ACLS; a++) add_row(CMD_CREATE, 2'(a), 0, 0, 0, 0, 1, 1);

    foreach (stim_table[i]) begin
      c = stim_table[i];
      send_command(c);
      if (stim_known[i]) begin
        want = pending_verdicts[$];
        typed = stim_expect[i];
        if (want.verdict !== typed.verdict)
          report_mismatch("directed verdict", want.verdict, typed.verdict);
        if (want.rport !== typed.rport)
          report_mismatch("directed redirect port", want.rport, typed.rport);
        if (want.matched !== typed.matched)
          report_mismatch("directed matched", want.matched, typed.matched);
        if (want.rule !== typed.rule)
          report_mismatch("directed matched rule", want.rule, typed.rule);
        if (want.ok !== typed.ok)
          report_mismatch("directed ok", want.ok, typed.ok);
      end
    end

    // Random part; pause once until drained, then fill the table past full
    for (int n = 0; n < 1600; n++) begin
      if (n == 400) begin
        in_valid <= 0;
        wait (pending_verdicts.size() == 0);
        @(negedge clk);
      end
      if (n >= 1450) no_idle = 1;
      c = random_command();
      if (n >= 600 && n < 680) begin
        c.op = CMD_ADD_RULE;
        c.rid = $urandom;
        c.acl = 2'($urandom);
      end
      send_command(c);
    end
    in_valid <= 0;

    wait (pending_verdicts.size() == 0);
    repeat (200) @(posedge clk);
    finished = 1;
    $display("ran %0d commands, %0d results checked", n_sent, n_checked);
    $display("%0d classifications, %0d of them hit a rule", n_classify, n_hits);
    if (errors == 0 && pending_verdicts.size() == 0) begin
      $display("acl_first_match_classifier regression: pass");
    end else begin
      $display("acl_first_match_classifier regression: fail");
    end
    $finish;
  end

endmodule

// File: files.f
design/acfm_pkg.sv
design/acfm_front.sv
design/acfm_fifo.sv
design/acfm_engine.sv
design/acl_first_match_classifier.sv
dv/tb.sv
